[hw/rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants, controller states and the command/status bundles of the
// sliding window median core.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int DATA_W  = 32;
  localparam int OUT_W   = DATA_W + 1;
  localparam int WIN_MAX = 64;
  localparam int IDX_W   = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int CNT_W   = IDX_W + 1;
  localparam int WS_W    = 7;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REM,
    ST_REM_TAIL,
    ST_INS,
    ST_INS_TAIL,
    ST_INS_FIN,
    ST_MED_A,
    ST_MED_B,
    ST_MED_SUM
  } state_e;

  typedef struct packed {
    logic load;
    logic disp_fill;
    logic disp_evict;
    logic rem_rd;
    logic proc_rem;
    logic ins_init;
    logic ins_rd;
    logic proc_ins;
    logic ins_fin;
    logic med_a;
    logic med_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
    logic win_one;
    logic rem_last;
    logic ins_last;
    logic out_free;
  } status_t;

  // window length as used: zero acts as one, large values saturate
  function automatic logic [CNT_W-1:0] eff_window(input logic [WS_W-1:0] ws);
    logic [CNT_W-1:0] res;
    if (ws == '0) begin
      res = CNT_W'(1);
    end else if (int'(ws) > WIN_MAX) begin
      res = CNT_W'(WIN_MAX);
    end else begin
      res = CNT_W'(ws);
    end
    return res;
  endfunction

endpackage

[hw/rtl/sliding_window_median_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_core
// Sliding-window median filter over signed 32-bit samples; emits twice the
// median once the window is full.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         in_valid/in_ready     sample_i, first_of_sequence_i
//  output    out        out_valid/out_ready   median_doubled_o
//  config    in/out     APB psel/penable      window_size at byte address 0
//
//  While the window is full, the removal and insertion scans each walk the
//  sorted RAM through its single read port, one entry a cycle. While
//  filling, only the insertion scan runs, over the samples already held.
//  Reset empties the window and sets window_size to 3; no clearing pass.
//  The next item is taken while a result still waits on the output; a
//  stalled output stalls the core only when the next result is ready.
// ----------------------------------------------------------------------------
module sliding_window_median_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [swm_pkg::DATA_W-1:0]  sample_i,
  input  logic                               first_of_sequence_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [swm_pkg::OUT_W-1:0]   median_doubled_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swm_pkg::ADDR_W-1:0]         paddr,
  input  logic [swm_pkg::PDATA_W-1:0]        pwdata,
  output logic [swm_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [swm_pkg::WS_W-1:0] window_size_q;
  logic                     cfg_wr;
  swm_pkg::cmd_t            cmd;
  swm_pkg::status_t         status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == swm_pkg::REG_WINDOW_SIZE)
                ? swm_pkg::PDATA_W'(window_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swm_pkg::WS_RESET;
    end else if (cfg_wr) begin
      window_size_q <= pwdata[swm_pkg::WS_W-1:0];
    end
  end

  swm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  swm_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_clear_i        (cfg_wr),
    .window_size_i      (window_size_q),
    .sample_i           (sample_i),
    .first_of_sequence_i(first_of_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .median_doubled_o   (median_doubled_o)
  );

endmodule

[hw/rtl/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer of the median core: dispatch, removal scan, insertion scan,
// median read and result hand-off.
// ----------------------------------------------------------------------------
module swm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swm_pkg::status_t status_i,
  output swm_pkg::cmd_t    cmd_o
);

  swm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = swm_pkg::ST_DISPATCH;
        end
      end
      swm_pkg::ST_DISPATCH: begin
        if (status_i.full) begin
          cmd_o.disp_evict = 1'b1;
          state_d          = swm_pkg::ST_REM;
        end else begin
          cmd_o.disp_fill = 1'b1;
          state_d = status_i.fill_zero ? swm_pkg::ST_INS_TAIL : swm_pkg::ST_INS;
        end
      end
      swm_pkg::ST_REM: begin
        cmd_o.rem_rd   = 1'b1;
        cmd_o.proc_rem = 1'b1;
        if (status_i.rem_last) begin
          state_d = swm_pkg::ST_REM_TAIL;
        end
      end
      swm_pkg::ST_REM_TAIL: begin
        // finish the last shift and set up insertion over the w-1 survivors
        cmd_o.proc_rem = 1'b1;
        cmd_o.ins_init = 1'b1;
        state_d = status_i.win_one ? swm_pkg::ST_INS_TAIL : swm_pkg::ST_INS;
      end
      swm_pkg::ST_INS: begin
        cmd_o.ins_rd   = 1'b1;
        cmd_o.proc_ins = 1'b1;
        if (status_i.ins_last) begin
          state_d = swm_pkg::ST_INS_TAIL;
        end
      end
      swm_pkg::ST_INS_TAIL: begin
        cmd_o.proc_ins = 1'b1;
        state_d        = swm_pkg::ST_INS_FIN;
      end
      swm_pkg::ST_INS_FIN: begin
        cmd_o.ins_fin = 1'b1;
        state_d = status_i.full ? swm_pkg::ST_MED_A : swm_pkg::ST_IDLE;
      end
      swm_pkg::ST_MED_A: begin
        cmd_o.med_a = 1'b1;
        state_d     = swm_pkg::ST_MED_B;
      end
      swm_pkg::ST_MED_B: begin
        cmd_o.med_b = 1'b1;
        state_d     = swm_pkg::ST_MED_SUM;
      end
      swm_pkg::ST_MED_SUM: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/swm_dp.sv]
// ----------------------------------------------------------------------------
// swm_dp
// Datapath of the median core: arrival ring and sorted store in RAM, window
// bookkeeping, scan counter and the result register.
// ----------------------------------------------------------------------------
module swm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swm_pkg::cmd_t                     cmd_i,
  output swm_pkg::status_t                  status_o,
  input  logic                              cfg_clear_i,
  input  logic [swm_pkg::WS_W-1:0]          window_size_i,
  input  logic signed [swm_pkg::DATA_W-1:0] sample_i,
  input  logic                              first_of_sequence_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [swm_pkg::OUT_W-1:0]  median_doubled_o
);

  localparam int IW = swm_pkg::IDX_W;
  localparam int CW = swm_pkg::CNT_W;
  localparam int DW = swm_pkg::DATA_W;
  localparam int OW = swm_pkg::OUT_W;

  logic [CW-1:0] win;
  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q;
  logic [IW-1:0] pend_idx_q;
  logic          found_q, found_d;
  logic          stop_q, stop_d;
  logic signed [DW-1:0] v_q;
  logic signed [DW-1:0] lo_q;
  logic          out_valid_q, out_valid_d;
  logic signed [OW-1:0] out_q;

  logic [IW-1:0] h_eff;
  logic [CW-1:0] h_next;
  logic [IW-1:0] mid_b, mid_a;

  logic          ring_we, ring_re;
  logic [IW-1:0] ring_waddr;
  logic [DW-1:0] ring_rdata;

  logic          srt_we, srt_re;
  logic [IW-1:0] srt_waddr, srt_raddr;
  logic [DW-1:0] srt_wdata, srt_rdata;

  logic signed [DW-1:0] old_s, rd_s;
  logic                 rd_gt_v;

  assign win     = swm_pkg::eff_window(window_size_i);
  assign h_eff   = (CW'(head_q) < win) ? head_q : '0;
  assign h_next  = CW'(h_eff) + CW'(1);
  assign mid_b   = IW'(win >> 1);
  assign mid_a   = win[0] ? mid_b : IW'(mid_b - IW'(1));
  assign old_s   = $signed(ring_rdata);
  assign rd_s    = $signed(srt_rdata);
  assign rd_gt_v = rd_s > v_q;

  assign status_o.full      = fill_q >= win;
  assign status_o.fill_zero = fill_q == '0;
  assign status_o.win_one   = win == CW'(1);
  assign status_o.rem_last  = cnt_q == (win - CW'(1));
  assign status_o.ins_last  = cnt_q == '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // ring: write the new sample, read the one it evicts (read-first)
  assign ring_we    = cmd_i.disp_fill || cmd_i.disp_evict;
  assign ring_re    = cmd_i.disp_evict;
  assign ring_waddr = cmd_i.disp_evict ? h_eff : fill_q[IW-1:0];

  always_comb begin
    fill_d      = fill_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    stop_d      = stop_q;
    out_valid_d = out_valid_q;
    srt_we      = 1'b0;
    srt_waddr   = '0;
    srt_wdata   = v_q;
    srt_re      = 1'b0;
    srt_raddr   = cnt_q[IW-1:0];

    if (cfg_clear_i || (cmd_i.load && first_of_sequence_i)) begin
      fill_d = '0;
      head_d = '0;
    end
    if (cmd_i.disp_fill) begin
      fill_d = fill_q + CW'(1);
      head_d = '0;
      cnt_d  = fill_q - CW'(1);
      stop_d = 1'b0;
    end
    if (cmd_i.disp_evict) begin
      head_d  = (h_next >= win) ? '0 : h_next[IW-1:0];
      cnt_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.ins_init) begin
      cnt_d  = win - CW'(2);
      stop_d = 1'b0;
    end

    if (cmd_i.rem_rd) begin
      srt_re = 1'b1;
      cnt_d  = cnt_q + CW'(1);
    end
    if (cmd_i.ins_rd) begin
      srt_re = 1'b1;
      cnt_d  = cnt_q - CW'(1);
    end
    if (cmd_i.med_a) begin
      srt_re    = 1'b1;
      srt_raddr = mid_a;
    end
    if (cmd_i.med_b) begin
      srt_re    = 1'b1;
      srt_raddr = mid_b;
    end

    // removal: find the evicted value, then shift the rest down by one
    if (cmd_i.proc_rem && pend_q) begin
      if (found_q) begin
        srt_we    = 1'b1;
        srt_waddr = pend_idx_q - IW'(1);
        srt_wdata = srt_rdata;
      end else if (rd_s == old_s) begin
        found_d = 1'b1;
      end
    end
    // insertion: shift larger entries up until the slot of the new sample
    if (cmd_i.proc_ins && pend_q && !stop_q) begin
      srt_we    = 1'b1;
      srt_waddr = pend_idx_q + IW'(1);
      srt_wdata = rd_gt_v ? srt_rdata : v_q;
      stop_d    = !rd_gt_v;
    end
    if (cmd_i.ins_fin && !stop_q) begin
      srt_we    = 1'b1;
      srt_waddr = '0;
      srt_wdata = v_q;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      pend_q      <= cmd_i.rem_rd || cmd_i.ins_rd;
      found_q     <= found_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= cnt_q[IW-1:0];
    if (cmd_i.load) begin
      v_q <= sample_i;
    end
    if (cmd_i.med_b) begin
      lo_q <= rd_s;
    end
    if (cmd_i.out_load) begin
      out_q <= OW'(lo_q) + OW'(rd_s);
    end
  end

  swm_ram #(
    .WIDTH(DW),
    .DEPTH(swm_pkg::WIN_MAX)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(v_q),
    .re_i   (ring_re),
    .raddr_i(h_eff),
    .rdata_o(ring_rdata)
  );

  swm_ram #(
    .WIDTH(DW),
    .DEPTH(swm_pkg::WIN_MAX)
  ) u_sorted (
    .clk_i  (clk_i),
    .we_i   (srt_we),
    .waddr_i(srt_waddr),
    .wdata_i(srt_wdata),
    .re_i   (srt_re),
    .raddr_i(srt_raddr),
    .rdata_o(srt_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = out_q;

endmodule

[hw/rtl/swm_checker.sv]
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the median core, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [swm_pkg::OUT_W-1:0]  median_doubled_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pready
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("result changed or dropped while stalled");

  // an accepted item keeps the core busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core ready right after taking an item");

  // a new result appears only out of the busy sequencer
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // register access never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("config access stalled");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (.*);
